// ===== design/lpht_pkg.sv =====
// shared types and constants of the linear probe hash table
package lpht_pkg;

   localparam int TABLE_SIZE_DEF = 16;

   localparam int KEY_W    = 31;
   localparam int SLOT_W   = 4;
   localparam int STATUS_W = 2;

   // home slot of a non power of two table: remainder taken a few key bits a cycle
   localparam int MOD_BITS  = 4;
   localparam int MOD_ITERS = (KEY_W + MOD_BITS - 1) / MOD_BITS;
   localparam int MOD_CNT_W = $clog2(MOD_ITERS);
   localparam int KEY_PAD   = MOD_ITERS * MOD_BITS;

   typedef logic [KEY_W-1:0]    key_type;
   typedef logic [SLOT_W-1:0]   slot_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_NOT_FOUND = 2'd1;
   localparam status_type STATUS_FULL      = 2'd2;
   localparam status_type STATUS_ZERO_KEY  = 2'd3;

endpackage

// ===== design/linear_probe_hash_table_top.sv =====
// open-addressing hash table of nonzero keys with linear probing
// a request probes p slots from its home slot, p = 1..TABLE_SIZE, and its response is registered
// non power of two TABLE_SIZE first works out the home slot remainder in S_MOD
// zero key answers without a probe; one request in flight, the next taken once the response loads
// probing is paced by the registered read of the slot memory, one slot per cycle
// reset starts a clearing pass over every slot, one slot a cycle, req_ready low meanwhile
module linear_probe_hash_table_top
   import lpht_pkg::*;
#(
   parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_opcode,
   input  key_type    req_key,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output slot_type   rsp_slot,
   output status_type rsp_status
);

   localparam int  AW      = $clog2(TABLE_SIZE);
   localparam bit  IS_POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_MOD    = 3'd2;
   localparam logic [2:0] S_READ   = 3'd3;
   localparam logic [2:0] S_CHECK  = 3'd4;
   localparam logic [2:0] S_RESULT = 3'd5;

   // slot memory, synchronous read
   key_type slot_mem [TABLE_SIZE];
   key_type rd_data_ff;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   key_type       mem_wdata;
   logic [AW-1:0] rd_addr;

   // control
   logic [2:0]           state_ff, state_in;
   logic [AW-1:0]        pos_ff, pos_in;        // probe slot, also the clear index
   logic [AW-1:0]        cnt_ff, cnt_in;        // probes done in this transaction
   logic [MOD_CNT_W-1:0] mod_cnt_ff, mod_cnt_in;

   // transaction payload
   logic                 op_ff, op_in;
   key_type              key_ff, key_in;
   logic [KEY_PAD-1:0]   mod_key_ff, mod_key_in;
   logic [AW-1:0]        mod_rem_ff, mod_rem_in;
   slot_type             res_slot_ff, res_slot_in;
   status_type           res_status_ff, res_status_in;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   slot_type             rsp_slot_ff, rsp_slot_in;
   status_type           rsp_status_ff, rsp_status_in;

   logic [AW-1:0]        pos_next;
   logic                 last_probe;
   logic [AW+SLOT_W-1:0] pos_wide;
   logic [AW-1:0]        mod_step_rem;
   logic [AW:0]          mod_t;
   logic [MOD_BITS-1:0]  mod_digit;

   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_slot   = rsp_slot_ff;
   assign rsp_status = rsp_status_ff;

   // linear probe step with wraparound
   assign pos_next   = (pos_ff == AW'(TABLE_SIZE - 1)) ? '0 : pos_ff + 1'b1;
   assign last_probe = (cnt_ff == AW'(TABLE_SIZE - 1));
   // slot field carries the low bits of the slot number
   assign pos_wide   = {{SLOT_W{1'b0}}, pos_ff};

   // a few restoring remainder steps, key bits taken msb first
   always_comb begin
      mod_digit    = mod_key_ff[KEY_PAD-1 -: MOD_BITS];
      mod_step_rem = mod_rem_ff;
      mod_t        = '0;
      for (int i = MOD_BITS - 1; i >= 0; i--) begin
         mod_t = {mod_step_rem, mod_digit[i]};
         if (mod_t >= (AW + 1)'(TABLE_SIZE)) begin
            mod_t = mod_t - (AW + 1)'(TABLE_SIZE);
         end
         mod_step_rem = mod_t[AW-1:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      cnt_in        = cnt_ff;
      mod_cnt_in    = mod_cnt_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      mod_key_in    = mod_key_ff;
      mod_rem_in    = mod_rem_ff;
      res_slot_in   = res_slot_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      mem_waddr     = pos_ff;
      mem_wdata     = '0;
      rd_addr       = pos_ff;

      case (state_ff)
         S_CLEAR: begin
            // empty every slot after reset
            mem_we = 1'b1;
            if (pos_ff == AW'(TABLE_SIZE - 1)) begin
               pos_in   = '0;
               state_in = S_IDLE;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in      = req_opcode;
               key_in     = req_key;
               cnt_in     = '0;
               mod_cnt_in = '0;
               mod_rem_in = '0;
               mod_key_in = KEY_PAD'(req_key);
               if (req_key == '0) begin
                  res_slot_in   = '0;
                  res_status_in = STATUS_ZERO_KEY;
                  state_in      = S_RESULT;
               end else if (IS_POW2) begin
                  pos_in   = req_key[AW-1:0];
                  state_in = S_READ;
               end else begin
                  state_in = S_MOD;
               end
            end
         end
         S_MOD: begin
            mod_rem_in = mod_step_rem;
            mod_key_in = mod_key_ff << MOD_BITS;
            mod_cnt_in = mod_cnt_ff + 1'b1;
            if (mod_cnt_ff == MOD_CNT_W'(MOD_ITERS - 1)) begin
               pos_in   = mod_step_rem;
               state_in = S_READ;
            end
         end
         S_READ: begin
            // home slot read issued here
            rd_addr  = pos_ff;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            // next slot read goes out every cycle, dropped once the probe ends
            rd_addr = pos_next;
            if (op_ff == OP_INSERT) begin
               if (rd_data_ff == '0) begin
                  mem_we        = 1'b1;
                  mem_waddr     = pos_ff;
                  mem_wdata     = key_ff;
                  res_slot_in   = pos_wide[SLOT_W-1:0];
                  res_status_in = STATUS_OK;
                  state_in      = S_RESULT;
               end else if (last_probe) begin
                  res_slot_in   = '0;
                  res_status_in = STATUS_FULL;
                  state_in      = S_RESULT;
               end else begin
                  pos_in = pos_next;
                  cnt_in = cnt_ff + 1'b1;
               end
            end else begin
               if (rd_data_ff == key_ff) begin
                  res_slot_in   = pos_wide[SLOT_W-1:0];
                  res_status_in = STATUS_OK;
                  state_in      = S_RESULT;
               end else if (rd_data_ff == '0 || last_probe) begin
                  res_slot_in   = '0;
                  res_status_in = STATUS_NOT_FOUND;
                  state_in      = S_RESULT;
               end else begin
                  pos_in = pos_next;
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         S_RESULT: begin
            // hand over once the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_slot_in   = res_slot_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // slot memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= slot_mem[rd_addr];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         pos_ff       <= '0;
         cnt_ff       <= '0;
         mod_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         cnt_ff       <= cnt_in;
         mod_cnt_ff   <= mod_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      mod_key_ff    <= mod_key_in;
      mod_rem_ff    <= mod_rem_in;
      res_slot_ff   <= res_slot_in;
      res_status_ff <= res_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

// ===== test/lpht_checker.sv =====
// response checker for the linear probe hash table: shadow table, expected queue, compare
`timescale 1ns / 100ps
module lpht_checker
   import lpht_pkg::*;
#(
   parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic       req_opcode,
   input  key_type    req_key,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  slot_type   rsp_slot,
   input  status_type rsp_status,
   output int         fail_count,
   output int         pending_count
);

   typedef struct packed {
      slot_type   slot;
      status_type status;
   } probe_result_type;

   key_type          shadow_slots [TABLE_SIZE];
   probe_result_type results_due [$];

   // walk the shadow table from the home slot, one pass at most
   function automatic probe_result_type probe_shadow(input logic op, input key_type key);
      probe_result_type res;
      int               pos;
      res.slot   = '0;
      res.status = STATUS_ZERO_KEY;
      if (key == '0) return res;
      res.status = (op == OP_INSERT) ? STATUS_FULL : STATUS_NOT_FOUND;
      pos = int'(key % TABLE_SIZE);
      for (int n = 0; n < TABLE_SIZE; n++) begin
         if (op == OP_INSERT && shadow_slots[pos] == '0) begin
            shadow_slots[pos] = key;
            res.slot   = slot_type'(pos);
            res.status = STATUS_OK;
            return res;
         end
         if (op == OP_SEARCH) begin
            if (shadow_slots[pos] == key) begin
               res.slot   = slot_type'(pos);
               res.status = STATUS_OK;
               return res;
            end
            if (shadow_slots[pos] == '0) return res;
         end
         pos = (pos == TABLE_SIZE - 1) ? 0 : pos + 1;
      end
      return res;
   endfunction

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin : watch
      probe_result_type due;
      if (reset) begin
         foreach (shadow_slots[i]) shadow_slots[i] = '0;
         results_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (results_due.size() == 0) begin
               $error("response with no transaction pending: slot %0d status %0d",
                      rsp_slot, rsp_status);
               fail_count++;
            end else begin
               due = results_due.pop_front();
               if (rsp_slot !== due.slot) begin
                  $error("slot mismatch: expected %0d, actual %0d", due.slot, rsp_slot);
                  fail_count++;
               end
               if (rsp_status !== due.status) begin
                  $error("status mismatch: expected %0d, actual %0d", due.status, rsp_status);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready)
            results_due = {results_due, probe_shadow(req_opcode, req_key)};
      end
      pending_count = results_due.size();
   end

endmodule

// ===== test/testbench.sv =====
// testbench top for the linear probe hash table: stimulus, flow control and verdict
`timescale 1ns / 100ps
module testbench;
   import lpht_pkg::*;

   localparam int RANDOM_ITEMS     = 1825;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int PAUSE_EVERY      = 600;
   localparam int DRAIN_CYCLES     = 40;
   localparam int TIMEOUT_NS       = 2_000_000;

   // receiver behavior over one stretch of cycles
   typedef enum {RX_STEADY, RX_CHOPPY, RX_STARVED} rx_mode_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_valid  = 1'b0;
   logic       req_ready;
   logic       req_opcode = OP_INSERT;
   key_type    req_key    = '0;
   logic       rsp_valid;
   logic       rsp_ready  = 1'b0;
   slot_type   rsp_slot;
   status_type rsp_status;

   int fail_count;
   int pending_count;

   // bumped by the sender to ask the receiver for one long hold-off
   int hold_requests = 0;

   // keys that went into the table, reused for searches that should hit
   key_type placed_keys [$];

   always #1 clock = ~clock;

   linear_probe_hash_table_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .req_key    (req_key),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_slot   (rsp_slot),
      .rsp_status (rsp_status)
   );

   lpht_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_key       (req_key),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_slot      (rsp_slot),
      .rsp_status    (rsp_status),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // present one transaction at the falling edge, return once it is taken
   task automatic offer_op(input logic op, input key_type key);
      @(negedge clock);
      req_valid  = 1'b1;
      req_opcode = op;
      req_key    = key;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // drop valid and stay quiet for a number of cycles
   task automatic idle_sender(input int cycles);
      @(negedge clock);
      req_valid = 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // sender pause until every response is back
   task automatic wait_for_responses();
      idle_sender(1);
      while (pending_count != 0) @(negedge clock);
   endtask

   // table is full by now: half hits on stored keys, plus misses over a
   // full pass, home-slot aliases, inserts that bounce and zero keys
   task automatic offer_random_op();
      int      pick;
      key_type key;
      key_type known;
      pick  = $urandom_range(0, 99);
      key   = key_type'($urandom);
      known = placed_keys[$urandom_range(0, placed_keys.size() - 1)];
      if (pick < 50)
         offer_op(OP_SEARCH, known);
      else if (pick < 65)
         offer_op(OP_SEARCH, key);
      else if (pick < 75)
         offer_op(OP_SEARCH, known ^ (key << 4));
      else if (pick < 92)
         offer_op(OP_INSERT, key);
      else
         offer_op(logic'($urandom_range(0, 1)), '0);
   endtask

   // receiver: stretches of steady, choppy and starved ready, plus the long hold-off
   initial begin : rsp_side
      int          stretch_left;
      int          holds_served;
      rx_mode_type mode;
      stretch_left = 0;
      holds_served = 0;
      mode         = RX_STEADY;
      forever begin
         @(negedge clock);
         if (hold_requests > holds_served) begin
            // block fills with two transactions and backs up the request side
            holds_served++;
            rsp_ready = 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
         end
         if (stretch_left == 0) begin
            stretch_left = $urandom_range(20, 200);
            mode         = rx_mode_type'($urandom_range(0, 2));
         end
         stretch_left--;
         case (mode)
            RX_STEADY:  rsp_ready = 1'b1;
            RX_CHOPPY:  rsp_ready = ($urandom_range(0, 1) == 1);
            default:    rsp_ready = ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   initial begin : stimulus
      int      sent;
      int      burst;
      int      gap;
      int      next_pause;
      key_type fill_key;

      repeat (5) @(negedge clock);
      reset = 1'b0;

      // directed part
      offer_op(OP_SEARCH, key_type'(5));             // empty table, miss at home
      offer_op(OP_INSERT, '0);                       // zero key rejected
      offer_op(OP_SEARCH, '0);
      offer_op(OP_INSERT, key_type'(31'h7fff_ffff)); // largest key, home 15
      offer_op(OP_INSERT, key_type'(31));            // home 15 taken, wraps to 0
      offer_op(OP_INSERT, key_type'(15));            // collision chain into slot 1
      offer_op(OP_INSERT, key_type'(31));            // duplicate lands in slot 2
      offer_op(OP_SEARCH, key_type'(31));            // nearest copy, found past the wrap
      offer_op(OP_SEARCH, key_type'(31'h7fff_ffff)); // hit on the home slot itself
      offer_op(OP_SEARCH, key_type'(47));            // miss after the wrap
      offer_op(OP_INSERT, key_type'(1));             // home 1 taken, goes to 3
      placed_keys = {placed_keys, key_type'(31'h7fff_ffff)};
      placed_keys = {placed_keys, key_type'(31)};
      placed_keys = {placed_keys, key_type'(15)};
      placed_keys = {placed_keys, key_type'(1)};
      // eleven keys of home 4 fill slots 4 through 14
      for (int i = 0; i < 11; i++) begin
         fill_key = (key_type'($urandom) & ~key_type'(15)) | key_type'(4);
         offer_op(OP_INSERT, fill_key);
         placed_keys = {placed_keys, fill_key};
      end
      offer_op(OP_INSERT, key_type'(9));             // full table
      offer_op(OP_SEARCH, key_type'(7));             // absent key, full pass, no empty slot
      offer_op(OP_SEARCH, key_type'(15));
      wait_for_responses();

      // random part in bursts
      sent       = 0;
      next_pause = PAUSE_EVERY;
      while (sent < RANDOM_ITEMS) begin
         if (sent >= 300 && hold_requests == 0) begin
            // receiver goes dark while the sender keeps pushing
            hold_requests++;
            repeat (20) begin
               offer_random_op();
               sent++;
            end
         end
         if (sent >= next_pause) begin
            wait_for_responses();
            next_pause += PAUSE_EVERY;
         end
         burst = $urandom_range(1, 12);
         repeat (burst) begin
            offer_random_op();
            sent++;
         end
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) idle_sender(gap);
      end

      wait_for_responses();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("linear_probe_hash_table_top test passed");
      else
         $display("linear_probe_hash_table_top test failed");
      $finish;
   end

   // hard stop if the handshakes hang
   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("linear_probe_hash_table_top test failed");
      $finish;
   end

endmodule
